// ===== rtl/core/dwmm_pkg.sv =====
package dwmm_pkg;

    // smaller of two window lengths
    function automatic int f_min(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // rank of the median in an ascending window of n entries (upper middle for even n)
    function automatic int f_median_rank(input int n);
        return n >> 1;
    endfunction

endpackage

// ===== rtl/core/dual_window_moving_median.sv =====
// a result is offered once its item is registered by the window cells, the rank stage
//   and the output stage; throughput: one item per cycle while the master side does not
//   stall, the rank stage comparing every cell against every other in one registered step
// reset (synchronous, active low): clears the fill count and the stage valid flags;
//   window cell contents are not cleared and are masked until enough items arrived
module dual_window_moving_median
    import dwmm_pkg::*;
#(
    parameter int SHORT_WINDOW = 3,
    parameter int LONG_WINDOW  = 5,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // slave side: one sample per item
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     s_axis_tdata,   // sample
    // master side: one result per item
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,   // short_median, long_median
    output logic [1:0]                            m_axis_tuser    // short_valid, long_valid
);

    localparam int ES     = f_min(SHORT_WINDOW, LONG_WINDOW);
    localparam int CW     = $clog2(LONG_WINDOW + 1);
    localparam int DW_OUT = ((2*SAMPLE_WIDTH+7)/8)*8;

    // stage flow control, each stage drains when its successor moves
    logic rdy1, rdy2, rdy3;
    logic accept;
    logic r_v1, r_v2, r_v3;

    assign rdy3   = !r_v3 || m_axis_tready;
    assign rdy2   = !r_v2 || rdy3;
    assign rdy1   = !r_v1 || rdy2;
    assign accept = s_axis_tvalid && rdy1;

    assign s_axis_tready = rdy1;

    // chain of cells, cell 0 holds the newest sample
    logic [LONG_WINDOW-1:0][SAMPLE_WIDTH-1:0] window;

    genvar g;
    generate
        for (g = 0; g < LONG_WINDOW; g++) begin : g_cell
            logic [SAMPLE_WIDTH-1:0] cell_in;
            if (g == 0) begin : g_head
                assign cell_in = s_axis_tdata[SAMPLE_WIDTH-1:0];
            end else begin : g_link
                assign cell_in = window[g-1];
            end
            dwmm_cell #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_cell (
                .i_clk    (i_clk),
                .i_shift  (accept),
                .i_sample (cell_in),
                .o_sample (window[g])
            );
        end
    endgenerate

    // saturating count of arrived items
    logic [CW-1:0] r_fill;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (accept && (r_fill != CW'(LONG_WINDOW))) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    // stage 1 -> 2: rank every cell, keep a copy of the window and the valid flags
    logic adv2;
    assign adv2 = r_v1 && rdy2;

    logic [ES-1:0]                            short_hit;
    logic [LONG_WINDOW-1:0]                   long_hit;
    logic [LONG_WINDOW-1:0][SAMPLE_WIDTH-1:0] r_win2;
    logic                                     r_sv2;
    logic                                     r_lv2;

    dwmm_rank #(
        .N            (ES),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_rank_short (
        .i_clk    (i_clk),
        .i_en     (adv2),
        .i_window (window[ES-1:0]),
        .o_hit    (short_hit)
    );

    dwmm_rank #(
        .N            (LONG_WINDOW),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_rank_long (
        .i_clk    (i_clk),
        .i_en     (adv2),
        .i_window (window),
        .o_hit    (long_hit)
    );

    always_ff @(posedge i_clk) begin
        if (adv2) begin
            r_win2 <= window;
            r_sv2  <= (r_fill >= CW'(ES));
            r_lv2  <= (r_fill == CW'(LONG_WINDOW));
        end
    end

    // stage 2 -> 3: and-or select of the ranked cell; tied hits carry equal values
    logic [SAMPLE_WIDTH-1:0] n_short_med;
    logic [SAMPLE_WIDTH-1:0] n_long_med;

    always_comb begin
        n_short_med = '0;
        n_long_med  = '0;
        for (int i = 0; i < ES; i++) begin
            n_short_med = n_short_med | (r_win2[i] & {SAMPLE_WIDTH{short_hit[i]}});
        end
        for (int i = 0; i < LONG_WINDOW; i++) begin
            n_long_med = n_long_med | (r_win2[i] & {SAMPLE_WIDTH{long_hit[i]}});
        end
        // a median not yet valid reads as zero
        n_short_med = n_short_med & {SAMPLE_WIDTH{r_sv2}};
        n_long_med  = n_long_med  & {SAMPLE_WIDTH{r_lv2}};
    end

    logic [SAMPLE_WIDTH-1:0] r_short_med;
    logic [SAMPLE_WIDTH-1:0] r_long_med;
    logic                    r_sv3;
    logic                    r_lv3;

    always_ff @(posedge i_clk) begin
        if (r_v2 && rdy3) begin
            r_short_med <= n_short_med;
            r_long_med  <= n_long_med;
            r_sv3       <= r_sv2;
            r_lv3       <= r_lv2;
        end
    end

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= accept;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = DW_OUT'({r_long_med, r_short_med});
    assign m_axis_tuser  = {r_lv3, r_sv3};

endmodule

// ===== rtl/core/dwmm_cell.sv =====
module dwmm_cell
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                    i_clk,
    input  logic                    i_shift,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    output logic [SAMPLE_WIDTH-1:0] o_sample
);

    logic [SAMPLE_WIDTH-1:0] r_sample;

    // take the neighbor's sample on every shift
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_sample <= i_sample;
        end
    end

    assign o_sample = r_sample;

endmodule

// ===== rtl/core/dwmm_rank.sv =====
module dwmm_rank
    import dwmm_pkg::*;
#(
    parameter int N            = 5,
    parameter int SAMPLE_WIDTH = 16
)
(
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [N-1:0][SAMPLE_WIDTH-1:0]   i_window,
    output logic [N-1:0]                     o_hit
);

    localparam int CN = $clog2(N + 1);
    localparam int K  = f_median_rank(N);

    logic [N-1:0][CN-1:0] lt_cnt;
    logic [N-1:0][CN-1:0] le_cnt;
    logic [N-1:0]         n_hit;
    logic [N-1:0]         r_hit;

    // element i holds the median when lt <= k < le
    always_comb begin
        for (int i = 0; i < N; i++) begin
            lt_cnt[i] = '0;
            le_cnt[i] = '0;
            for (int j = 0; j < N; j++) begin
                lt_cnt[i] = lt_cnt[i]
                    + CN'($signed(i_window[j]) <  $signed(i_window[i]));
                le_cnt[i] = le_cnt[i]
                    + CN'($signed(i_window[j]) <= $signed(i_window[i]));
            end
            n_hit[i] = (lt_cnt[i] <= CN'(K)) && (CN'(K) < le_cnt[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_hit <= n_hit;
        end
    end

    assign o_hit = r_hit;

endmodule

// ===== rtl/core/dwmm_checker.sv =====
module dwmm_checker
#(
    parameter int SAMPLE_WIDTH = 16
)
(
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   m_axis_tdata,
    input logic [1:0]                            m_axis_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // the long window can only be full if the short one is
    a_valid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("long_valid without short_valid");

    // medians not yet valid read as zero
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[SAMPLE_WIDTH-1:0] == '0)
        else $error("short median not zero while invalid");

    a_long_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[1]
            |-> m_axis_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH] == '0)
        else $error("long median not zero while invalid");

    // once the long window is valid it stays valid for later results
    a_long_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tuser[1]
            ##1 m_axis_tvalid |-> m_axis_tuser[1])
        else $error("long_valid dropped");

endmodule

bind dual_window_moving_median dwmm_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_dwmm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
